>>> src/xmod_pkg.sv
package xmod_pkg;

  localparam logic [4:0] REG_NONE = 5'd16;

  localparam logic [2:0] SEG_ES = 3'd0;
  localparam logic [2:0] SEG_CS = 3'd1;
  localparam logic [2:0] SEG_SS = 3'd2;
  localparam logic [2:0] SEG_DS = 3'd3;
  localparam logic [2:0] SEG_FS = 3'd4;
  localparam logic [2:0] SEG_GS = 3'd5;

  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  localparam logic [2:0] RM_SIB  = 3'b100;
  localparam logic [2:0] RM_DISP = 3'b101;
  localparam logic [2:0] IDX_NONE = 3'b100;
  localparam logic [2:0] BASE_DISP = 3'b101;

  localparam logic [2:0] DISP_NONE = 3'd0;
  localparam logic [2:0] DISP_BYTE = 3'd1;
  localparam logic [2:0] DISP_DWORD = 3'd4;

  typedef enum logic [3:0] {
    SC_B     = 4'd0,
    SC_W     = 4'd1,
    SC_D     = 4'd2,
    SC_Q     = 4'd3,
    SC_V     = 4'd4,
    SC_Z     = 4'd5,
    SC_VD64  = 4'd6,
    SC_A     = 4'd7,
    SC_P     = 4'd8,
    SC_S     = 4'd9,
    SC_TBYTE = 4'd10,
    SC_ENV   = 4'd11,
    SC_STATE = 4'd12,
    SC_RVMW  = 4'd13
  } size_class_t;

  // ModRM fields with REX already qualified by mode
  typedef struct packed {
    logic [1:0] mod;
    logic [2:0] reg_f;
    logic [2:0] rm;
    logic       rex;
    logic       w;
    logic       r;
    logic       x;
    logic       b;
  } fields_t;

  typedef struct packed {
    logic [4:0] base;
    logic [4:0] index;
    logic [1:0] scale;
    logic [2:0] disp;
    logic       rip;
    logic [2:0] seg;
  } addr_t;

  function automatic fields_t split_fields(logic [7:0] modrm, logic rex_present,
                                           logic [3:0] wrxb, logic long_mode);
    fields_t f;
    logic    rex;
    rex = long_mode & rex_present;
    f.mod   = modrm[7:6];
    f.reg_f = modrm[5:3];
    f.rm    = modrm[2:0];
    f.rex   = rex;
    f.w     = rex & wrxb[3];
    f.r     = rex & wrxb[2];
    f.x     = rex & wrxb[1];
    f.b     = rex & wrxb[0];
    return f;
  endfunction

endpackage

>>> src/xmod_size.sv
module xmod_size (
  input  logic [3:0] size_class,
  input  logic       w,
  input  logic       op16,
  input  logic       is_reg,
  input  logic       long_mode,
  output logic [6:0] bytes
);

  logic [6:0] size_v;

  assign size_v = w ? 7'd8 : (op16 ? 7'd2 : 7'd4);

  always_comb begin
    unique case (size_class)
      xmod_pkg::SC_B:     bytes = 7'd1;
      xmod_pkg::SC_W:     bytes = 7'd2;
      xmod_pkg::SC_D:     bytes = 7'd4;
      xmod_pkg::SC_Q:     bytes = 7'd8;
      xmod_pkg::SC_V:     bytes = size_v;
      xmod_pkg::SC_Z:     bytes = (!w && op16) ? 7'd2 : 7'd4;
      xmod_pkg::SC_VD64: begin
        if (w || (long_mode && !op16)) bytes = 7'd8;
        else if (op16)                 bytes = 7'd2;
        else                           bytes = 7'd4;
      end
      xmod_pkg::SC_A:     bytes = op16 ? 7'd4 : 7'd8;
      xmod_pkg::SC_P:     bytes = op16 ? 7'd4 : 7'd6;
      xmod_pkg::SC_S:     bytes = 7'd6;
      xmod_pkg::SC_TBYTE: bytes = 7'd10;
      xmod_pkg::SC_ENV:   bytes = op16 ? 7'd14 : 7'd28;
      xmod_pkg::SC_STATE: bytes = op16 ? 7'd94 : 7'd108;
      xmod_pkg::SC_RVMW:  bytes = is_reg ? size_v : 7'd2;
      default:            bytes = 7'd4;
    endcase
  end

endmodule

>>> src/xmod_addr.sv
module xmod_addr (
  input  xmod_pkg::fields_t f,
  input  logic [7:0]        sib,
  input  logic              long_mode,
  input  logic              seg_ovr_valid,
  input  logic [2:0]        seg_ovr,
  output xmod_pkg::addr_t   a
);

  logic [3:0] sidx;
  logic [4:0] base;
  logic [4:0] index;
  logic [1:0] scale;
  logic [2:0] disp;
  logic       rip;
  logic       no_disp;

  assign sidx    = {f.x, sib[5:3]};
  assign no_disp = (f.mod == xmod_pkg::MOD_NODISP);

  always_comb begin
    base  = xmod_pkg::REG_NONE;
    index = xmod_pkg::REG_NONE;
    scale = 2'd0;
    disp  = xmod_pkg::DISP_NONE;
    rip   = 1'b0;
    if (f.rm == xmod_pkg::RM_SIB) begin
      scale = sib[7:6];
      // index 100 is "none" only with REX.X clear
      if (sidx != {1'b0, xmod_pkg::IDX_NONE}) index = {1'b0, sidx};
      if (no_disp && sib[2:0] == xmod_pkg::BASE_DISP) begin
        disp = xmod_pkg::DISP_DWORD;
      end else begin
        base = {1'b0, f.b, sib[2:0]};
      end
    end else if (no_disp && f.rm == xmod_pkg::RM_DISP) begin
      disp = xmod_pkg::DISP_DWORD;
      rip  = long_mode;
    end else begin
      base = {1'b0, f.b, f.rm};
    end
    if (f.mod == xmod_pkg::MOD_DISP8)       disp = xmod_pkg::DISP_BYTE;
    else if (f.mod == xmod_pkg::MOD_DISP32) disp = xmod_pkg::DISP_DWORD;
  end

  always_comb begin
    a.base  = base;
    a.index = index;
    a.scale = scale;
    a.disp  = disp;
    a.rip   = rip;
    priority if (seg_ovr_valid) begin
      a.seg = (seg_ovr <= xmod_pkg::SEG_GS) ? seg_ovr : xmod_pkg::SEG_DS;
    end else if (base == 5'd4 || base == 5'd5) begin
      a.seg = xmod_pkg::SEG_SS;
    end else begin
      a.seg = xmod_pkg::SEG_DS;
    end
  end

endmodule

>>> src/x86_modrm_operand_decode_unit.sv
// Decodes one ModRM/SIB operand descriptor per item. An item passes an input
// register, one level of field decode and a result register. The decoded item
// moves on into the result register whenever no finished result is stalled.
// A new item is taken every cycle while the result side does not stall.
// While a finished result waits, the input register takes at most one more
// item and then stalls the input. cfg_wdata selects 64-bit decode (1) or
// 32-bit decode (0); write it only while no item is in flight.
module x86_modrm_operand_decode_unit (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_we,
  input  logic       cfg_wdata,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_modrm,
  input  logic [7:0] in_sib,
  input  logic       in_rex_present,
  input  logic [3:0] in_rex_wrxb,
  input  logic       in_opsize_prefix,
  input  logic       in_seg_override_valid,
  input  logic [2:0] in_seg_override,
  input  logic [3:0] in_size_class,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_register,
  output logic [3:0] out_rm_reg,
  output logic [3:0] out_reg_reg,
  output logic       out_high_byte_reg,
  output logic [4:0] out_base_reg,
  output logic [4:0] out_index_reg,
  output logic [1:0] out_scale_shift,
  output logic [2:0] out_disp_bytes,
  output logic       out_rip_relative,
  output logic [2:0] out_segment,
  output logic [6:0] out_operand_bytes
);

  logic long_mode_r;

  logic       s1_valid_r;
  logic [7:0] s1_modrm_r;
  logic [7:0] s1_sib_r;
  logic       s1_rex_r;
  logic [3:0] s1_wrxb_r;
  logic       s1_op16_r;
  logic       s1_ovr_valid_r;
  logic [2:0] s1_ovr_r;
  logic [3:0] s1_cls_r;

  logic out_valid_r;
  logic out_is_register_r;
  logic [3:0] out_rm_reg_r;
  logic [3:0] out_reg_reg_r;
  logic out_high_byte_reg_r;
  xmod_pkg::addr_t out_addr_r;
  logic [6:0] out_operand_bytes_r;

  logic s2_en;
  logic s1_en;
  logic in_take;

  xmod_pkg::fields_t f;
  xmod_pkg::addr_t   addr;
  logic [6:0]        bytes;
  logic              is_reg;
  logic              high;

  assign s2_en    = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;
  assign in_take  = in_valid && s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b0;
    end else if (cfg_we) begin
      long_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_modrm_r     <= in_modrm;
      s1_sib_r       <= in_sib;
      s1_rex_r       <= in_rex_present;
      s1_wrxb_r      <= in_rex_wrxb;
      s1_op16_r      <= in_opsize_prefix;
      s1_ovr_valid_r <= in_seg_override_valid;
      s1_ovr_r       <= in_seg_override;
      s1_cls_r       <= in_size_class;
    end
  end

  assign f      = xmod_pkg::split_fields(s1_modrm_r, s1_rex_r, s1_wrxb_r, long_mode_r);
  assign is_reg = (f.mod == xmod_pkg::MOD_REG);

  xmod_size u_size (
    .size_class (s1_cls_r),
    .w          (f.w),
    .op16       (s1_op16_r),
    .is_reg     (is_reg),
    .long_mode  (long_mode_r),
    .bytes      (bytes)
  );

  xmod_addr u_addr (
    .f             (f),
    .sib           (s1_sib_r),
    .long_mode     (long_mode_r),
    .seg_ovr_valid (s1_ovr_valid_r),
    .seg_ovr       (s1_ovr_r),
    .a             (addr)
  );

  // legacy AH..BH: byte operand, rm 4..7, no REX
  assign high = is_reg && (bytes == 7'd1) && !f.rex && f.rm[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      out_is_register_r   <= is_reg;
      out_rm_reg_r        <= {f.b, f.rm};
      out_reg_reg_r       <= {f.r, f.reg_f};
      out_high_byte_reg_r <= high;
      out_operand_bytes_r <= bytes;
      if (is_reg) begin
        out_addr_r.base  <= xmod_pkg::REG_NONE;
        out_addr_r.index <= xmod_pkg::REG_NONE;
        out_addr_r.scale <= 2'd0;
        out_addr_r.disp  <= xmod_pkg::DISP_NONE;
        out_addr_r.rip   <= 1'b0;
        out_addr_r.seg   <= xmod_pkg::SEG_DS;
      end else begin
        out_addr_r <= addr;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_register   = out_is_register_r;
  assign out_rm_reg        = out_rm_reg_r;
  assign out_reg_reg       = out_reg_reg_r;
  assign out_high_byte_reg = out_high_byte_reg_r;
  assign out_base_reg      = out_addr_r.base;
  assign out_index_reg     = out_addr_r.index;
  assign out_scale_shift   = out_addr_r.scale;
  assign out_disp_bytes    = out_addr_r.disp;
  assign out_rip_relative  = out_addr_r.rip;
  assign out_segment       = out_addr_r.seg;
  assign out_operand_bytes = out_operand_bytes_r;

endmodule

>>> src/xmod_chk.sv
module xmod_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_is_register,
  input logic       out_high_byte_reg,
  input logic [4:0] out_base_reg,
  input logic [4:0] out_index_reg,
  input logic [2:0] out_disp_bytes,
  input logic       out_rip_relative,
  input logic [2:0] out_segment,
  input logic [6:0] out_operand_bytes
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("item dropped while stalled");

  a_reg_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_register |->
      out_base_reg == xmod_pkg::REG_NONE && out_index_reg == xmod_pkg::REG_NONE &&
      out_disp_bytes == xmod_pkg::DISP_NONE && !out_rip_relative &&
      out_segment == xmod_pkg::SEG_DS)
    else $error("register operand carries memory fields");

  a_high_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_byte_reg |-> out_is_register && out_operand_bytes == 7'd1)
    else $error("high-byte flag on non-byte or memory operand");

  a_rip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rip_relative |->
      out_disp_bytes == xmod_pkg::DISP_DWORD && out_base_reg == xmod_pkg::REG_NONE &&
      out_index_reg == xmod_pkg::REG_NONE)
    else $error("RIP-relative form malformed");

  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_segment <= xmod_pkg::SEG_GS && out_operand_bytes != 7'd0)
    else $error("bad segment or zero operand size");

endmodule

bind x86_modrm_operand_decode_unit xmod_chk u_xmod_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_is_register   (out_is_register),
  .out_high_byte_reg (out_high_byte_reg),
  .out_base_reg      (out_base_reg),
  .out_index_reg     (out_index_reg),
  .out_disp_bytes    (out_disp_bytes),
  .out_rip_relative  (out_rip_relative),
  .out_segment       (out_segment),
  .out_operand_bytes (out_operand_bytes)
);
